[hdl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define HGOV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hgov: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define HGOV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hgov: next-cycle check failed");

`endif

[hdl/hgov_pkg.sv]
`default_nettype none

package hgov_pkg;

   // Width of the cumulative idle and wall counters that take part in the deltas.
   localparam int COUNTER_WIDTH = 64;

   // Bits of a busy percent (0..100).
   localparam int PCT_BITS = 7;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_AUTO_ENABLE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FORCED_CORE_ON = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DECISION_LOCK  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LOAD_LOW       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LOAD_HIGH      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_INTERVAL  = 3'd5;

   // Reset values of the threshold and base interval registers.
   localparam logic [6:0]  RESET_LOAD_LOW  = 7'd25;
   localparam logic [6:0]  RESET_LOAD_HIGH = 7'd70;
   localparam logic [15:0] RESET_BASE      = 16'd50;

   // Core 1 command codes.
   localparam logic [1:0] CMD_NONE    = 2'd0;
   localparam logic [1:0] CMD_ONLINE  = 2'd1;
   localparam logic [1:0] CMD_OFFLINE = 2'd2;

   // Status codes.
   localparam logic [2:0] STS_EVALUATED = 3'd0;
   localparam logic [2:0] STS_LOCKED    = 3'd1;
   localparam logic [2:0] STS_BAD       = 3'd2;
   localparam logic [2:0] STS_PARKED    = 3'd3;
   localparam logic [2:0] STS_MANUAL    = 3'd4;

   typedef struct packed {
      logic [63:0] idle_total_core0;
      logic [63:0] wall_total_core0;
      logic [63:0] idle_total_core1;
      logic [63:0] wall_total_core1;
      logic        display_off;
   } req_type;

   typedef struct packed {
      logic [1:0]  core1_command;
      logic        core1_online_now;
      logic [6:0]  average_load;
      logic [17:0] next_interval;
      logic        keep_sampling;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic        auto_enable;
      logic        forced_core_on;
      logic        decision_lock;
      logic [6:0]  load_low;
      logic [6:0]  load_high;
      logic [15:0] base_interval;
   } cfg_type;

endpackage

`default_nettype wire

[hdl/hgov_pct_div.sv]
`default_nettype none

// Busy percent unit: floor(100 * busy / wall) for busy <= wall, wall > 0.
// The quotient never exceeds 100, so a 7-step restoring division of the
// scaled busy count against wall << 6 .. wall << 0 gives it.
module hgov_pct_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [hgov_pkg::COUNTER_WIDTH-1:0] busy,
   input  wire logic [hgov_pkg::COUNTER_WIDTH-1:0] wall,
   output logic                                   done,
   output logic [hgov_pkg::PCT_BITS-1:0]          quotient
);

   localparam int REM_W  = hgov_pkg::COUNTER_WIDTH + hgov_pkg::PCT_BITS;
   localparam int STEP_W = $clog2(hgov_pkg::PCT_BITS);

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_SCALE,
      DV_STEP
   } dv_state_type;

   dv_state_type                         state_ff, state_in;
   logic                                 done_ff, done_in;
   logic [hgov_pkg::COUNTER_WIDTH-1:0]   busy_ff, busy_in;
   logic [REM_W-1:0]                     rem_ff, rem_in;
   logic [REM_W-1:0]                     divisor_ff, divisor_in;
   logic [hgov_pkg::PCT_BITS-1:0]        q_ff, q_in;
   logic [STEP_W-1:0]                    step_ff, step_in;

   logic [REM_W-1:0] busy_ext;
   logic [REM_W:0]   trial;
   logic             fits;

   assign busy_ext = REM_W'(busy_ff);
   assign trial    = {1'b0, rem_ff} - {1'b0, divisor_ff};
   assign fits     = ~trial[REM_W];

   // Sequencer and datapath next values
   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      busy_in    = busy_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      q_in       = q_ff;
      step_in    = step_ff;
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               busy_in    = busy;
               divisor_in = REM_W'(wall) << (hgov_pkg::PCT_BITS - 1);
               q_in       = '0;
               step_in    = STEP_W'(hgov_pkg::PCT_BITS - 1);
               state_in   = DV_SCALE;
            end
         end
         DV_SCALE: begin
            // 100 * busy = 64b + 32b + 4b
            rem_in   = (busy_ext << 6) + (busy_ext << 5) + (busy_ext << 2);
            state_in = DV_STEP;
         end
         DV_STEP: begin
            if (fits) begin
               rem_in = trial[REM_W-1:0];
            end
            q_in       = {q_ff[hgov_pkg::PCT_BITS-2:0], fits};
            divisor_in = divisor_ff >> 1;
            step_in    = step_ff - 1'b1;
            if (step_ff == '0) begin
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      busy_ff    <= busy_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      q_ff       <= q_in;
      step_ff    <= step_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

[hdl/hgov_cfg.sv]
`default_nettype none

// Configuration register file, write only.
module hgov_cfg (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [hgov_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [hgov_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output hgov_pkg::cfg_type                        cfg
);

   hgov_pkg::cfg_type cfg_ff, cfg_in;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            hgov_pkg::REG_AUTO_ENABLE:    cfg_in.auto_enable    = csr_wdata[0];
            hgov_pkg::REG_FORCED_CORE_ON: cfg_in.forced_core_on = csr_wdata[0];
            hgov_pkg::REG_DECISION_LOCK:  cfg_in.decision_lock  = csr_wdata[0];
            hgov_pkg::REG_LOAD_LOW:       cfg_in.load_low       = csr_wdata[6:0];
            hgov_pkg::REG_LOAD_HIGH:      cfg_in.load_high      = csr_wdata[6:0];
            hgov_pkg::REG_BASE_INTERVAL:  cfg_in.base_interval  = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_enable    <= 1'b1;
         cfg_ff.forced_core_on <= 1'b1;
         cfg_ff.decision_lock  <= 1'b0;
         cfg_ff.load_low       <= hgov_pkg::RESET_LOAD_LOW;
         cfg_ff.load_high      <= hgov_pkg::RESET_LOAD_HIGH;
         cfg_ff.base_interval  <= hgov_pkg::RESET_BASE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hdl/load_threshold_core_hotplug_governor_core.sv]
`default_nettype none

// Load-threshold hotplug governor for a two-core cluster. One item per
// sampling tick carries the cumulative idle and wall counters of both cores;
// the block returns one result item with the core 1 command, the average
// busy percent and the next sampling interval. Items are handled one at a
// time and req_stall stays high while one is in work. Ticks that are parked,
// locked or in manual mode go from acceptance straight to ST_DONE; an
// evaluated tick passes each online core in turn through the shared 7-step
// percent divider, skipped by a core with a zero wall delta. A bad sample
// ends evaluation at the core where it is seen. The result sits in an output
// register, so a new item is taken while the previous result still waits.
module load_threshold_core_hotplug_governor_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire hgov_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output hgov_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [hgov_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [hgov_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW = hgov_pkg::COUNTER_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORE,
      ST_CHECK,
      ST_WAIT,
      ST_DECIDE,
      ST_DONE
   } state_type;

   hgov_pkg::cfg_type cfg;

   state_type          state_ff, state_in;
   hgov_pkg::req_type  req_ff, req_in;
   hgov_pkg::rsp_type  res_ff, res_in;
   hgov_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               c_ff, c_in;
   logic [7:0]         sum_ff, sum_in;
   logic [CW-1:0]      di_ff, di_in;
   logic [CW-1:0]      dw_ff, dw_in;
   logic [CW-1:0]      prev_idle_ff [2];
   logic [CW-1:0]      prev_idle_in [2];
   logic [CW-1:0]      prev_wall_ff [2];
   logic [CW-1:0]      prev_wall_in [2];
   logic               online_ff, online_in;
   logic [17:0]        interval_ff, interval_in;

   logic                          div_start;
   logic                          div_done;
   logic [hgov_pkg::PCT_BITS-1:0] div_q;

   logic [CW-1:0]  cur_idle;
   logic [CW-1:0]  cur_wall;
   logic [CW:0]    busy_diff;
   logic [15:0]    base_ticks;
   logic [7:0]     avg8;
   logic [6:0]     avg;
   logic           more_cores;

   hgov_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hgov_pct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .busy     (busy_diff[CW-1:0]),
      .wall     (dw_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Counters of the core under evaluation
   assign cur_idle = c_ff ? req_ff.idle_total_core1[CW-1:0] : req_ff.idle_total_core0[CW-1:0];
   assign cur_wall = c_ff ? req_ff.wall_total_core1[CW-1:0] : req_ff.wall_total_core0[CW-1:0];

   // Busy delta; the borrow flags idle delta above wall delta
   assign busy_diff = {1'b0, dw_ff} - {1'b0, di_ff};

   assign base_ticks = (cfg.base_interval == '0) ? 16'd1 : cfg.base_interval;
   assign more_cores = ~c_ff & online_ff;

   // Average over one or two online cores
   assign avg8 = online_ff ? {1'b0, sum_ff[7:1]} : sum_ff;
   assign avg  = avg8[6:0];

   assign req_stall = (state_ff != ST_IDLE);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      c_in         = c_ff;
      sum_in       = sum_ff;
      di_in        = di_ff;
      dw_in        = dw_ff;
      prev_idle_in = prev_idle_ff;
      prev_wall_in = prev_wall_ff;
      online_in    = online_ff;
      interval_in  = interval_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in                  = req_data;
               res_in.core1_command    = hgov_pkg::CMD_NONE;
               res_in.core1_online_now = online_ff;
               res_in.average_load     = '0;
               res_in.next_interval    = interval_ff;
               res_in.keep_sampling    = 1'b1;
               res_in.status           = hgov_pkg::STS_LOCKED;
               state_in                = ST_DONE;
               if (req_data.display_off && !online_ff) begin
                  res_in.keep_sampling = 1'b0;
                  res_in.status        = hgov_pkg::STS_PARKED;
               end else if (!cfg.auto_enable) begin
                  // Manual mode enforces the forced setting both ways
                  res_in.keep_sampling = 1'b0;
                  res_in.status        = hgov_pkg::STS_MANUAL;
                  if (cfg.forced_core_on != online_ff) begin
                     online_in               = cfg.forced_core_on;
                     res_in.core1_online_now = cfg.forced_core_on;
                     res_in.core1_command    = cfg.forced_core_on ? hgov_pkg::CMD_ONLINE
                                                                  : hgov_pkg::CMD_OFFLINE;
                  end
               end else if (!cfg.decision_lock) begin
                  c_in     = 1'b0;
                  sum_in   = '0;
                  state_in = ST_CORE;
               end
            end
         end
         ST_CORE: begin
            // Deltas modulo counter width; old counters replaced after use
            di_in              = cur_idle - prev_idle_ff[c_ff];
            dw_in              = cur_wall - prev_wall_ff[c_ff];
            prev_idle_in[c_ff] = cur_idle;
            prev_wall_in[c_ff] = cur_wall;
            state_in           = ST_CHECK;
         end
         ST_CHECK: begin
            if (busy_diff[CW]) begin
               res_in.core1_command    = hgov_pkg::CMD_NONE;
               res_in.core1_online_now = online_ff;
               res_in.average_load     = '0;
               res_in.next_interval    = interval_ff;
               res_in.keep_sampling    = 1'b1;
               res_in.status           = hgov_pkg::STS_BAD;
               state_in                = ST_DONE;
            end else if (dw_ff == '0) begin
               // zero wall delta counts as load 0
               c_in     = 1'b1;
               state_in = more_cores ? ST_CORE : ST_DECIDE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_done) begin
               sum_in   = sum_ff + 8'(div_q);
               c_in     = 1'b1;
               state_in = more_cores ? ST_CORE : ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_in.core1_command    = hgov_pkg::CMD_NONE;
            res_in.core1_online_now = online_ff;
            res_in.average_load     = avg;
            res_in.next_interval    = interval_ff;
            res_in.keep_sampling    = 1'b1;
            res_in.status           = hgov_pkg::STS_EVALUATED;
            // Hysteresis on the average load
            if (avg < cfg.load_low && online_ff) begin
               online_in               = 1'b0;
               interval_in             = {2'b00, base_ticks};
               res_in.core1_command    = hgov_pkg::CMD_OFFLINE;
               res_in.core1_online_now = 1'b0;
               res_in.next_interval    = {2'b00, base_ticks};
            end else if (avg > cfg.load_high && !online_ff) begin
               online_in               = 1'b1;
               interval_in             = {base_ticks, 2'b00};
               res_in.core1_command    = hgov_pkg::CMD_ONLINE;
               res_in.core1_online_now = 1'b1;
               res_in.next_interval    = {base_ticks, 2'b00};
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hand over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         prev_idle_ff[0] <= '0;
         prev_idle_ff[1] <= '0;
         prev_wall_ff[0] <= '0;
         prev_wall_ff[1] <= '0;
         online_ff       <= 1'b1;
         interval_ff     <= {2'b00, hgov_pkg::RESET_BASE};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_idle_ff <= prev_idle_in;
         prev_wall_ff <= prev_wall_in;
         online_ff    <= online_in;
         interval_ff  <= interval_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      c_ff   <= c_in;
      sum_ff <= sum_in;
      di_ff  <= di_in;
      dw_ff  <= dw_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[hdl/hgov_checker.sv]
`default_nettype none

`include "assert_macros.svh"

// Port-level checks for the governor.
module hgov_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire hgov_pkg::rsp_type                 rsp_data
);

   logic req_take;
   logic rsp_shown;
   logic cmd_sent;
   logic cmd_matches;
   logic not_evaluated;
   logic parked;
   logic quiet_park;

   assign req_take  = req_valid & ~req_stall;
   assign rsp_shown = rsp_valid;

   assign cmd_sent      = rsp_shown && (rsp_data.core1_command != hgov_pkg::CMD_NONE);
   assign cmd_matches   = (rsp_data.core1_online_now ==
                           (rsp_data.core1_command == hgov_pkg::CMD_ONLINE));
   assign not_evaluated = rsp_shown && (rsp_data.status != hgov_pkg::STS_EVALUATED);
   assign parked        = rsp_shown && (rsp_data.status == hgov_pkg::STS_PARKED);
   assign quiet_park    = !rsp_data.keep_sampling && !rsp_data.core1_online_now &&
                          (rsp_data.core1_command == hgov_pkg::CMD_NONE);

   // A stalled result stays offered
   `HGOV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // An accepted item keeps the block busy in the next cycle
   `HGOV_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, req_stall)
   // A command agrees with the reported core 1 state
   `HGOV_ASSERT_IMPLY(a_cmd_state, clock, reset, cmd_sent, cmd_matches)
   // Only an evaluated tick reports a load
   `HGOV_ASSERT_IMPLY(a_load_only_eval, clock, reset, not_evaluated, rsp_data.average_load == '0)
   // A parked tick neither switches nor schedules
   `HGOV_ASSERT_IMPLY(a_park_quiet, clock, reset, parked, quiet_park)

endmodule

bind load_threshold_core_hotplug_governor_core hgov_checker u_hgov_checker (.*);

`default_nettype wire
